FILE: hdl/ctt_pkg.sv
`default_nettype none

package ctt_pkg;

    localparam int RUN_MAX = 5;

    localparam logic [7:0]  BACKTICK    = 8'h60;
    localparam logic [15:0] CP_BACKTICK = 16'h0060;
    localparam logic [15:0] CP_IO_CAP   = 16'h0401;
    localparam logic [15:0] CP_IO_SMALL = 16'h0451;
    localparam logic [15:0] CP_CYR_LO   = 16'h0410;
    localparam logic [15:0] CP_CYR_HI   = 16'h044F;
    localparam logic [6:0]  ASCII_O_CAP   = 7'h4F;
    localparam logic [6:0]  ASCII_O_SMALL = 7'h6F;

    // backtick follows the letter for these offsets from U+0410
    localparam logic [31:0] ENC_TICK = 32'hE780_0040;

    typedef struct packed {
        logic [15:0] code_accum;
        logic [1:0]  bytes_left;
        logic [6:0]  pending_letter;
        logic        pending_valid;
    } ctt_state_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [2:0]              count;
    } ctt_run_t;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
    } ctt_utf8_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } ctt_letter_t;

    function automatic ctt_letter_t letter_index(input logic [15:0] cp);
        ctt_letter_t r;
        r.hit = 1'b0;
        r.idx = '0;
        if (cp >= 16'h0041 && cp <= 16'h005A)
        begin
            r.hit = 1'b1;
            r.idx = 5'(cp - 16'h0041);
        end
        else if (cp >= 16'h0061 && cp <= 16'h007A)
        begin
            r.hit = 1'b1;
            r.idx = 5'(cp - 16'h0061);
        end
        return r;
    endfunction

    // capital plain letter per ASCII letter, zero where unmapped
    function automatic logic [10:0] dec_plain(input logic [4:0] idx);
        logic [10:0] r;
        case (idx)
            5'd0:  r = 11'h410;
            5'd1:  r = 11'h411;
            5'd2:  r = 11'h426;
            5'd3:  r = 11'h414;
            5'd4:  r = 11'h415;
            5'd5:  r = 11'h424;
            5'd6:  r = 11'h413;
            5'd7:  r = 11'h425;
            5'd8:  r = 11'h418;
            5'd9:  r = 11'h419;
            5'd10: r = 11'h41A;
            5'd11: r = 11'h41B;
            5'd12: r = 11'h41C;
            5'd13: r = 11'h41D;
            5'd14: r = 11'h41E;
            5'd15: r = 11'h41F;
            5'd17: r = 11'h420;
            5'd18: r = 11'h421;
            5'd19: r = 11'h422;
            5'd20: r = 11'h423;
            5'd21: r = 11'h412;
            5'd23: r = 11'h42C;
            5'd24: r = 11'h42B;
            5'd25: r = 11'h417;
            default: r = '0;
        endcase
        return r;
    endfunction

    // capital backtick variant per ASCII letter, zero where none
    function automatic logic [10:0] dec_variant(input logic [4:0] idx);
        logic [10:0] r;
        case (idx)
            5'd0:  r = 11'h42F;
            5'd2:  r = 11'h427;
            5'd4:  r = 11'h42D;
            5'd7:  r = 11'h429;
            5'd9:  r = 11'h416;
            5'd14: r = 11'h401;
            5'd18: r = 11'h428;
            5'd20: r = 11'h42E;
            5'd23: r = 11'h42A;
            default: r = '0;
        endcase
        return r;
    endfunction

    // capital ascii letter per offset from U+0410
    function automatic logic [6:0] enc_letter(input logic [4:0] off);
        logic [6:0] r;
        case (off)
            5'd0:  r = 7'h41;
            5'd1:  r = 7'h42;
            5'd2:  r = 7'h56;
            5'd3:  r = 7'h47;
            5'd4:  r = 7'h44;
            5'd5:  r = 7'h45;
            5'd6:  r = 7'h4A;
            5'd7:  r = 7'h5A;
            5'd8:  r = 7'h49;
            5'd9:  r = 7'h4A;
            5'd10: r = 7'h4B;
            5'd11: r = 7'h4C;
            5'd12: r = 7'h4D;
            5'd13: r = 7'h4E;
            5'd14: r = 7'h4F;
            5'd15: r = 7'h50;
            5'd16: r = 7'h52;
            5'd17: r = 7'h53;
            5'd18: r = 7'h54;
            5'd19: r = 7'h55;
            5'd20: r = 7'h46;
            5'd21: r = 7'h48;
            5'd22: r = 7'h43;
            5'd23: r = 7'h43;
            5'd24: r = 7'h53;
            5'd25: r = 7'h48;
            5'd26: r = 7'h58;
            5'd27: r = 7'h59;
            5'd28: r = 7'h58;
            5'd29: r = 7'h45;
            5'd30: r = 7'h55;
            5'd31: r = 7'h41;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] to_case(input logic [10:0] cap, input logic lower);
        logic [10:0] r;
        r = cap;
        if (lower)
        begin
            if (cap == CP_IO_CAP[10:0])
                r = CP_IO_SMALL[10:0];
            else
                r = cap + 11'h020;
        end
        return r;
    endfunction

    function automatic ctt_utf8_t utf8(input logic [15:0] cp);
        ctt_utf8_t r;
        r.data = '0;
        if (cp < 16'h0080)
        begin
            r.data[0] = cp[7:0];
            r.count   = 2'd1;
        end
        else if (cp < 16'h0800)
        begin
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
            r.count   = 2'd2;
        end
        else
        begin
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
            r.count   = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ctt_step.sv
`default_nettype none

module ctt_step
(
    input  wire ctt_pkg::ctt_state_t cur,
    input  wire logic [7:0]          in_byte,
    input  wire logic                is_end,
    input  wire logic                decode_mode,
    output ctt_pkg::ctt_state_t      nxt,
    output ctt_pkg::ctt_run_t        run
);

    logic [15:0]          merged;
    logic                 done;
    logic [15:0]          cp;
    logic                 flush_do;
    logic                 flush_var;
    logic                 process;
    ctt_pkg::ctt_letter_t pend_li;
    ctt_pkg::ctt_letter_t cp_li;
    logic [10:0]          cap;
    logic [10:0]          plain;
    logic [10:0]          variant;
    logic [5:0]           off6;
    ctt_pkg::ctt_utf8_t   fu;
    ctt_pkg::ctt_utf8_t   pu;
    logic [3:0]           total;

    // fold the continuation byte into the code point
    always_comb
    begin
        case (cur.bytes_left)
            2'd1:    merged = cur.code_accum | {10'b0, in_byte[5:0]};
            2'd2:    merged = cur.code_accum | {4'b0, in_byte[5:0], 6'b0};
            2'd3:    merged = cur.code_accum | {in_byte[3:0], 12'b0};
            default: merged = cur.code_accum;
        endcase
    end

    always_comb
    begin
        nxt       = cur;
        done      = 1'b0;
        cp        = '0;
        flush_do  = 1'b0;
        flush_var = 1'b0;
        process   = 1'b0;
        fu        = '0;
        pu        = '0;
        cap       = '0;
        off6      = '0;
        cp_li     = '0;
        plain     = '0;
        variant   = '0;

        // utf-8 assembly
        if (is_end)
        begin
            nxt.code_accum = '0;
            nxt.bytes_left = '0;
        end
        else if (cur.bytes_left != 2'd0)
        begin
            nxt.bytes_left = cur.bytes_left - 2'd1;
            if (cur.bytes_left == 2'd1)
            begin
                done           = 1'b1;
                cp             = merged;
                nxt.code_accum = '0;
            end
            else
            begin
                nxt.code_accum = merged;
            end
        end
        else if (!in_byte[7])
        begin
            done = 1'b1;
            cp   = {8'b0, in_byte};
        end
        else if (!in_byte[5])
        begin
            nxt.code_accum = {5'b0, in_byte[4:0], 6'b0};
            nxt.bytes_left = 2'd1;
        end
        else
        begin
            nxt.code_accum = {in_byte[3:0], 12'b0};
            nxt.bytes_left = 2'd2;
        end

        // pending letter resolution
        if (is_end)
        begin
            flush_do = cur.pending_valid;
        end
        else if (done)
        begin
            if (cur.pending_valid && cp == ctt_pkg::CP_BACKTICK)
            begin
                flush_do  = 1'b1;
                flush_var = 1'b1;
            end
            else
            begin
                flush_do = cur.pending_valid;
                process  = 1'b1;
            end
        end

        pend_li = ctt_pkg::letter_index({9'b0, cur.pending_letter});
        if (flush_do)
        begin
            if (pend_li.hit)
                cap = flush_var ? ctt_pkg::dec_variant(pend_li.idx)
                                : ctt_pkg::dec_plain(pend_li.idx);
            if (cap != 11'd0)
                fu = ctt_pkg::utf8({5'b0, ctt_pkg::to_case(cap, cur.pending_letter[5])});
            nxt.pending_valid  = 1'b0;
            nxt.pending_letter = '0;
        end

        // code point under the current mode
        if (process)
        begin
            if (decode_mode)
            begin
                cp_li = ctt_pkg::letter_index(cp);
                if (cp_li.hit)
                begin
                    plain   = ctt_pkg::dec_plain(cp_li.idx);
                    variant = ctt_pkg::dec_variant(cp_li.idx);
                end
                if (cp_li.hit && plain != 11'd0)
                begin
                    if (variant != 11'd0)
                    begin
                        nxt.pending_letter = cp[6:0];
                        nxt.pending_valid  = 1'b1;
                    end
                    else
                    begin
                        pu = ctt_pkg::utf8({5'b0, ctt_pkg::to_case(plain, cp[5])});
                    end
                end
                else
                begin
                    pu = ctt_pkg::utf8(cp);
                end
            end
            else if (cp == ctt_pkg::CP_IO_CAP || cp == ctt_pkg::CP_IO_SMALL)
            begin
                pu.data[0] = {1'b0, (cp == ctt_pkg::CP_IO_CAP) ? ctt_pkg::ASCII_O_CAP
                                                               : ctt_pkg::ASCII_O_SMALL};
                pu.data[1] = ctt_pkg::BACKTICK;
                pu.count   = 2'd2;
            end
            else if (cp >= ctt_pkg::CP_CYR_LO && cp <= ctt_pkg::CP_CYR_HI)
            begin
                off6       = 6'(cp - ctt_pkg::CP_CYR_LO);
                pu.data[0] = {1'b0, ctt_pkg::enc_letter(off6[4:0]) | {1'b0, off6[5], 5'b0}};
                if (ctt_pkg::ENC_TICK[off6[4:0]])
                begin
                    pu.data[1] = ctt_pkg::BACKTICK;
                    pu.count   = 2'd2;
                end
                else
                begin
                    pu.count = 2'd1;
                end
            end
            else
            begin
                pu = ctt_pkg::utf8(cp);
            end
        end
    end

    // flush bytes first, then the code point bytes
    always_comb
    begin
        total = {2'b0, fu.count} + {2'b0, pu.count};
        run.count = (total > 4'(ctt_pkg::RUN_MAX)) ? 3'(ctt_pkg::RUN_MAX) : total[2:0];
        for (int i = 0; i < ctt_pkg::RUN_MAX; i++)
        begin
            if (i < int'(fu.count))
                run.data[i] = fu.data[i[1:0]];
            else if (i - int'(fu.count) < int'(pu.count))
                run.data[i] = pu.data[2'(i - int'(fu.count))];
            else
                run.data[i] = '0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ctt_run_buf.sv
`default_nettype none

module ctt_run_buf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ctt_pkg::ctt_run_t run,
    input  wire logic              out_stall,
    output logic                   free,
    output logic [7:0]             out_byte,
    output logic                   run_last,
    output logic                   out_valid
);

    logic [ctt_pkg::RUN_MAX-1:0][7:0] data_reg;
    logic [ctt_pkg::RUN_MAX-1:0][7:0] data_next;
    logic [2:0]                       count_reg;
    logic [2:0]                       count_next;
    logic                             take;

    assign out_valid = (count_reg != 3'd0);
    assign run_last  = (count_reg == 3'd1);
    assign out_byte  = data_reg[0];
    assign take      = out_valid && !out_stall;
    // room for a new run once the last beat leaves
    assign free      = !out_valid || (run_last && !out_stall);

    always_comb
    begin
        data_next  = data_reg;
        count_next = count_reg;
        if (load)
        begin
            data_next  = run.data;
            count_next = run.count;
        end
        else if (take)
        begin
            for (int i = 0; i < ctt_pkg::RUN_MAX - 1; i++)
                data_next[i] = data_reg[i + 1];
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/cyrillic_translit_transcoder_unit.sv
`default_nettype none

// Cyrillic transliteration transcoder. A UTF-8 byte stream enters one byte per
// beat; code points of one to three bytes are assembled (F0 and above count as
// 3-byte leads, continuation bytes are not checked). With decode_mode at 0 the
// Cyrillic letters U+0410..U+044F, U+0401 and U+0451 leave as one ascii letter,
// some followed by a backtick, and every other code point is sent back out as
// UTF-8. With decode_mode at 1 ascii letters other than Q, W, q and w become
// Cyrillic letters as 2-byte UTF-8; the letters that have a backtick variant
// wait for the next code point, a backtick picks the variant and anything
// else sends the plain letter and is then handled itself. An input beat with
// is_end set flushes a waiting letter and drops an unfinished sequence. Each
// input beat gives zero to five output beats; run_last marks the last output
// beat of one input beat. Rate: the output port moves one byte per cycle
// while out_stall is low, so an input beat that gives bytes holds the input
// until its last byte leaves, and the next input beat can be taken in the
// cycle the last byte leaves. decode_mode is written through the cfg port,
// which is always ready; write it only while no output is outstanding.
module cyrillic_translit_transcoder_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    // input byte stream
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_end,
    // output byte stream
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last
);

    logic                 decode_mode_reg;
    ctt_pkg::ctt_state_t  state_reg;
    ctt_pkg::ctt_state_t  state_next;
    ctt_pkg::ctt_run_t    run;
    logic                 buf_free;
    logic                 in_fire;

    // config register, taken on any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decode_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            decode_mode_reg <= cfg_data;
    end

    // input beat taken whenever the run buffer can take its results
    assign in_stall = !buf_free;
    assign in_fire  = in_valid && !in_stall;

    // assembly, pending letter and mapping for one beat
    ctt_step u_step
    (
        .cur         (state_reg),
        .in_byte     (in_byte),
        .is_end      (is_end),
        .decode_mode (decode_mode_reg),
        .nxt         (state_next),
        .run         (run)
    );

    // transcoder state advances only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

    // result bytes, one per output beat
    ctt_run_buf u_run_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .run       (run),
        .out_stall (out_stall),
        .free      (buf_free),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_valid (out_valid)
    );

    // a new beat only overlaps the last byte of the previous run
    a_overlap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid) |-> (run_last && !out_stall))
        else $error("input beat accepted while output run not finishing");

    // a waiting letter is always an ascii letter
    a_pending_letter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending_valid |->
            ((state_reg.pending_letter >= 7'h41 && state_reg.pending_letter <= 7'h5A) ||
             (state_reg.pending_letter >= 7'h61 && state_reg.pending_letter <= 7'h7A)))
        else $error("pending letter outside ascii letters");

    // at most two continuation bytes are ever expected
    a_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_left != 2'd3)
        else $error("continuation count out of range");

    // an end beat leaves no sequence under assembly and no waiting letter
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_end) |=> (state_reg.bytes_left == 2'd0 && !state_reg.pending_valid))
        else $error("end beat left state behind");

endmodule

`default_nettype wire
